/* rtl/psc_pkg.sv */
// Package: item types and fixed constants for the pair-sum counter.
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

  // Width of a value, a target and a count
  localparam int DATA_W = 32;

  // Set tag kept beside each bucket head; a full sweep runs when it wraps
  localparam int EPOCH_W = 8;

  // Remainder unit: dividend bits consumed per cycle, and remainder steps per hash
  localparam int HASH_STEP_BITS = 4;
  localparam int HASH_CYCLES    = DATA_W / HASH_STEP_BITS;
  localparam int HASH_CNT_W     = $clog2(HASH_CYCLES);

  // One input item
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_item;
  } psc_in_t;

  // One result item
  typedef struct packed {
    logic [DATA_W-1:0] pair_count;
    logic              overflowed;
  } psc_out_t;

endpackage : psc_pkg

`default_nettype wire

/* rtl/psc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module psc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : psc_ram

`default_nettype wire

/* rtl/pair_sum_counter_hash_chained_core.sv */
// Top level: pair-sum counter over a chained hash table with a node pool.
//
// Usage: write target_sum on the cfg channel (cfg_valid/cfg_ready, always
// ready) while the block is idle. Feed the values of a set one item at a time:
// an item is taken on a clock edge with start high and busy low; the final
// item of the set carries last_item. After that item's insert the block puts
// pair_count and overflowed on out_item for exactly one cycle with out_valid
// high, then empties its table for the next set. The receiver cannot stall;
// a result appears once and is gone the next cycle.
// Per item (busy high) the block hashes target_sum - value, walks that
// bucket's chain counting keys equal to it, then hashes the value and links
// it in as its bucket's new head; the next item is taken back in idle. The
// chain walk reads one node per cycle from the single read port of the node
// pool RAM. The bucket index comes from one shared remainder unit, 4 bits
// per cycle, or is the low magnitude bits when BUCKETS is a power of two.
// Reset (rst_n low, synchronous) zeroes target_sum and starts a sweep of the
// bucket-head RAM, which keeps busy high. The same sweep follows the
// end of every 256th set, when the set tag of the head entries wraps.
`timescale 1ns / 1ps
`default_nettype none

module pair_sum_counter_hash_chained_core
  import psc_pkg::*;
#(
  parameter int BUCKETS   = 256,
  parameter int MAX_ITEMS = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // input channel
  input  wire logic                     start,
  output logic                          busy,
  input  wire psc_in_t                  in_item,
  // result channel
  output logic                          out_valid,
  output psc_out_t                      out_item,
  // configuration channel
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic signed [DATA_W-1:0] cfg_target_sum
);

  // Bucket index, link (node number + 1) and node address widths
  localparam int IW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int LW  = $clog2(MAX_ITEMS + 1);
  localparam int NAW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int HW  = EPOCH_W + LW;
  localparam int NW  = DATA_W + LW;

  localparam bit BKT_POW2 = (BUCKETS > 1) && ((BUCKETS & (BUCKETS - 1)) == 0);
  localparam logic [IW:0]   BKT_C    = (IW + 1)'(BUCKETS);
  localparam logic [IW-1:0] BKT_LAST = IW'(BUCKETS - 1);
  localparam logic [LW-1:0] POOL_MAX = LW'(MAX_ITEMS);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH_C,
    S_HEAD_RD,
    S_HEAD_CHK,
    S_NODE_CHK,
    S_HASH_V,
    S_INS_RD,
    S_INS_WR
  } state_t;

  // Two's complement magnitude, with the most negative value as 2^31
  function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] key);
    magnitude = key[DATA_W-1] ? (~key + 1'b1) : key;
  endfunction

  // Control registers
  state_t                  state_r, state_nxt;
  logic [IW-1:0]           clr_r, clr_nxt;
  logic [EPOCH_W-1:0]      epoch_r, epoch_nxt;
  logic [LW-1:0]           nodes_used_r, nodes_used_nxt;
  logic [DATA_W-1:0]       count_r, count_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [DATA_W-1:0]       target_r, target_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [HASH_CNT_W-1:0]   hcnt_r, hcnt_nxt;

  // Payload registers
  logic [DATA_W-1:0]       val_r, val_nxt;
  logic [DATA_W-1:0]       comp_r, comp_nxt;
  logic                    last_r, last_nxt;
  logic [DATA_W-1:0]       mag_r, mag_nxt;
  logic [IW-1:0]           rem_r, rem_nxt;
  logic [IW-1:0]           bkt_r, bkt_nxt;
  psc_out_t                out_item_r, out_item_nxt;

  // Remainder unit outputs
  logic                    hash_done;
  logic [IW-1:0]           hash_step;
  logic [IW-1:0]           hash_idx;

  // RAM ports
  logic                    head_we, head_re;
  logic [IW-1:0]           head_waddr;
  logic [HW-1:0]           head_wdata, head_rdata;
  logic                    node_we, node_re;
  logic [NW-1:0]           node_wdata, node_rdata;
  logic [NAW-1:0]          node_raddr;

  // Decoded read data
  logic [LW-1:0]           head_link, node_link, walk_link, link_m1, chain_head;
  logic [EPOCH_W-1:0]      head_tag;
  logic                    head_live, pool_full, key_hit;
  logic [DATA_W-1:0]       node_key;

  logic                    in_accept;

  assign in_accept = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Shared remainder unit: HASH_STEP_BITS restoring steps per cycle on mag_r
  always_comb begin
    logic [IW:0] t;
    logic [IW-1:0] r;
    r = rem_r;
    for (int k = 0; k < HASH_STEP_BITS; k++) begin
      t = {r, mag_r[DATA_W-1-k]};
      if (t >= BKT_C) begin
        t = t - BKT_C;
      end
      r = t[IW-1:0];
    end
    hash_step = r;
    if (BKT_POW2) begin
      hash_done = 1'b1;
      hash_idx  = mag_r[IW-1:0];
    end else begin
      hash_done = (hcnt_r == HASH_CNT_W'(HASH_CYCLES - 1));
      hash_idx  = r;
    end
  end

  // Head and node decode
  assign head_link  = head_rdata[LW-1:0];
  assign head_tag   = head_rdata[HW-1:LW];
  assign head_live  = (head_tag == epoch_r) && (head_link != '0);
  assign chain_head = head_live ? head_link : '0;
  assign node_link  = node_rdata[LW-1:0];
  assign node_key   = node_rdata[NW-1:LW];
  assign key_hit    = (node_key == comp_r);
  assign pool_full  = (nodes_used_r >= POOL_MAX);

  // Chain walk: next node address straight from the read data
  assign walk_link  = (state_r == S_HEAD_CHK) ? chain_head : node_link;
  assign link_m1    = walk_link - 1'b1;
  assign node_raddr = link_m1[NAW-1:0];
  assign node_re    = ((state_r == S_HEAD_CHK) || (state_r == S_NODE_CHK)) &&
                      (walk_link != '0);

  // Head RAM access: sweep or insert writes, bucket reads
  assign head_re    = (state_r == S_HEAD_RD) || (state_r == S_INS_RD);
  assign head_we    = (state_r == S_CLEAR) || ((state_r == S_INS_WR) && !pool_full);
  assign head_waddr = (state_r == S_CLEAR) ? clr_r : bkt_r;
  assign head_wdata = (state_r == S_CLEAR) ? '0 : {epoch_r, nodes_used_r + 1'b1};

  // Node pool insert
  assign node_we    = (state_r == S_INS_WR) && !pool_full;
  assign node_wdata = {val_r, chain_head};

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    epoch_nxt      = epoch_r;
    nodes_used_nxt = nodes_used_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    target_nxt     = target_r;
    out_valid_nxt  = 1'b0;
    hcnt_nxt       = hcnt_r;
    val_nxt        = val_r;
    comp_nxt       = comp_r;
    last_nxt       = last_r;
    mag_nxt        = mag_r;
    rem_nxt        = rem_r;
    bkt_nxt        = bkt_r;
    out_item_nxt   = out_item_r;

    if (cfg_valid && cfg_ready) begin
      target_nxt = cfg_target_sum;
    end

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == BKT_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          val_nxt   = in_item.value;
          last_nxt  = in_item.last_item;
          comp_nxt  = target_r - in_item.value;
          mag_nxt   = magnitude(target_r - in_item.value);
          rem_nxt   = '0;
          hcnt_nxt  = '0;
          state_nxt = S_HASH_C;
        end
      end
      S_HASH_C: begin
        if (hash_done) begin
          bkt_nxt   = hash_idx;
          state_nxt = S_HEAD_RD;
        end else begin
          mag_nxt  = mag_r << HASH_STEP_BITS;
          rem_nxt  = hash_step;
          hcnt_nxt = hcnt_r + 1'b1;
        end
      end
      S_HEAD_RD: begin
        state_nxt = S_HEAD_CHK;
      end
      S_HEAD_CHK, S_NODE_CHK: begin
        // count a matching key, then follow the link
        if ((state_r == S_NODE_CHK) && key_hit) begin
          if (&count_r) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        if (node_re) begin
          state_nxt = S_NODE_CHK;
        end else begin
          mag_nxt   = magnitude(val_r);
          rem_nxt   = '0;
          hcnt_nxt  = '0;
          state_nxt = S_HASH_V;
        end
      end
      S_HASH_V: begin
        if (hash_done) begin
          bkt_nxt   = hash_idx;
          state_nxt = S_INS_RD;
        end else begin
          mag_nxt  = mag_r << HASH_STEP_BITS;
          rem_nxt  = hash_step;
          hcnt_nxt = hcnt_r + 1'b1;
        end
      end
      S_INS_RD: begin
        state_nxt = S_INS_WR;
      end
      S_INS_WR: begin
        if (pool_full) begin
          ovf_nxt = 1'b1;
        end else begin
          nodes_used_nxt = nodes_used_r + 1'b1;
        end
        state_nxt = S_IDLE;
        // end of set: report, then start a fresh set tag
        if (last_r) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.pair_count = count_r;
          out_item_nxt.overflowed = ovf_r | pool_full;
          nodes_used_nxt          = '0;
          count_nxt               = '0;
          ovf_nxt                 = 1'b0;
          epoch_nxt               = epoch_r + 1'b1;
          if (&epoch_r) begin
            clr_nxt   = '0;
            state_nxt = S_CLEAR;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, control and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      epoch_r      <= '0;
      nodes_used_r <= '0;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      target_r     <= '0;
      out_valid_r  <= 1'b0;
      hcnt_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      epoch_r      <= epoch_nxt;
      nodes_used_r <= nodes_used_nxt;
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
      target_r     <= target_nxt;
      out_valid_r  <= out_valid_nxt;
      hcnt_r       <= hcnt_nxt;
    end
    val_r      <= val_nxt;
    comp_r     <= comp_nxt;
    last_r     <= last_nxt;
    mag_r      <= mag_nxt;
    rem_r      <= rem_nxt;
    bkt_r      <= bkt_nxt;
    out_item_r <= out_item_nxt;
  end

  // Bucket heads: {set tag, link}
  psc_ram #(
    .WIDTH (HW),
    .DEPTH (BUCKETS)
  ) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .re    (head_re),
    .raddr (bkt_r),
    .rdata (head_rdata)
  );

  // Node pool: {key, link}
  psc_ram #(
    .WIDTH (NW),
    .DEPTH (MAX_ITEMS)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (nodes_used_r[NAW-1:0]),
    .wdata (node_wdata),
    .re    (node_re),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  // Checks
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (nodes_used_r == '0) && (count_r == '0) && !ovf_r)
    else $error("set state not cleared after result");

  a_walk_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    node_re |-> (walk_link <= nodes_used_r))
    else $error("chain walk reached a node not written in this set");

  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nodes_used_r <= POOL_MAX)
    else $error("node pool count beyond pool size");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> busy)
    else $error("accepted item did not make the block busy");

endmodule : pair_sum_counter_hash_chained_core

`default_nettype wire
